[hw/rtl/vmcr_pkg.sv]
// ----------------------------------------------------------------------------
// vmcr_pkg
// Shared types and constants of the virtio-MMIO console register block.
// ----------------------------------------------------------------------------
package vmcr_pkg;

   localparam int NUM_QUEUES = 2;
   localparam int QUEUE_MAX_SIZE = 256;
   localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

   localparam logic [31:0] MAGIC_WORD = 32'h7472_6976;
   localparam logic [31:0] VERSION_WORD = 32'd2;
   localparam logic [31:0] DEVICE_ID_WORD = 32'd3;
   localparam logic [31:0] VENDOR_WORD = 32'h4348_4950;
   localparam logic [31:0] CONSOLE_COLS = 32'd80;
   localparam logic [31:0] CONSOLE_ROWS = 32'd25;
   localparam logic [31:0] QUEUE_MAX_WORD = 32'(QUEUE_MAX_SIZE);
   localparam logic [31:0] QUEUE_COUNT_WORD = 32'(NUM_QUEUES);

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_RAISE = 2'd2
   } req_kind_type;

   // register offsets in the MMIO window
   localparam logic [11:0] OFS_MAGIC       = 12'h000;
   localparam logic [11:0] OFS_VERSION     = 12'h004;
   localparam logic [11:0] OFS_DEVICE_ID   = 12'h008;
   localparam logic [11:0] OFS_VENDOR      = 12'h00c;
   localparam logic [11:0] OFS_DEV_FEAT    = 12'h010;
   localparam logic [11:0] OFS_DEV_FEAT_SEL = 12'h014;
   localparam logic [11:0] OFS_DRV_FEAT    = 12'h020;
   localparam logic [11:0] OFS_DRV_FEAT_SEL = 12'h024;
   localparam logic [11:0] OFS_QUEUE_SEL   = 12'h030;
   localparam logic [11:0] OFS_QUEUE_MAX   = 12'h034;
   localparam logic [11:0] OFS_QUEUE_SIZE  = 12'h038;
   localparam logic [11:0] OFS_QUEUE_READY = 12'h044;
   localparam logic [11:0] OFS_INT_STATUS  = 12'h060;
   localparam logic [11:0] OFS_INT_ACK     = 12'h064;
   localparam logic [11:0] OFS_STATUS      = 12'h070;
   localparam logic [11:0] OFS_DESC_LO     = 12'h080;
   localparam logic [11:0] OFS_DESC_HI     = 12'h084;
   localparam logic [11:0] OFS_DRIVER_LO   = 12'h090;
   localparam logic [11:0] OFS_DRIVER_HI   = 12'h094;
   localparam logic [11:0] OFS_DEVICE_LO   = 12'h0a0;
   localparam logic [11:0] OFS_DEVICE_HI   = 12'h0a4;
   localparam logic [11:0] OFS_COLS        = 12'h100;
   localparam logic [11:0] OFS_ROWS        = 12'h102;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [11:0] offset;
      logic [3:0]  access_len;
      logic [31:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [63:0] sel_desc_addr;
      logic [63:0] sel_driver_addr;
      logic [63:0] sel_device_addr;
      logic [31:0] device_status;
      logic        irq_pending;
   } rsp_item_type;

   // request held in the input register
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } req_stage_type;

   // transaction leaving the register file
   typedef struct packed {
      logic        valid;
      logic [31:0] read_data;
   } done_stage_type;

   // state view driven from the register file
   typedef struct packed {
      logic [63:0] sel_desc_addr;
      logic [63:0] sel_driver_addr;
      logic [63:0] sel_device_addr;
      logic [31:0] device_status;
      logic        irq_pending;
   } state_view_type;

endpackage

[hw/rtl/vmcr_req_stage.sv]
// ----------------------------------------------------------------------------
// vmcr_req_stage
// Input register: captures each accepted request transaction.
// ----------------------------------------------------------------------------
module vmcr_req_stage
   import vmcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  req_item_type  item,
   output req_stage_type stage
);

   logic         valid_ff;
   req_item_type item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

[hw/rtl/vmcr_regfile.sv]
// ----------------------------------------------------------------------------
// vmcr_regfile
// Register state, read decode and write decode of the console register map.
// ----------------------------------------------------------------------------
module vmcr_regfile
   import vmcr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  req_stage_type  stage,
   output done_stage_type done,
   output state_view_type view
);

   logic [31:0] dev_feat_sel_ff;
   logic [31:0] drv_feat_sel_ff;
   logic [31:0] drv_feat_word_ff [2];
   logic [31:0] qsel_ff;
   logic [31:0] queue_size_ff  [NUM_QUEUES];
   logic [31:0] queue_ready_ff [NUM_QUEUES];
   logic [63:0] desc_addr_ff   [NUM_QUEUES];
   logic [63:0] driver_addr_ff [NUM_QUEUES];
   logic [63:0] device_addr_ff [NUM_QUEUES];
   logic [31:0] status_ff;
   logic        irq_ff;
   logic        irq_in;
   logic        done_valid_ff;
   logic [31:0] read_data_ff;
   logic [31:0] read_data_in;
   logic [31:0] read_raw;

   logic              q_valid;
   logic [QIDX_W-1:0] qidx;
   logic              drv_idx;
   logic              is_read;
   logic              is_write;
   logic              is_raise;
   logic              soft_clear;
   logic [11:0]       ofs;
   logic [31:0]       wdata;

   assign ofs      = stage.item.offset;
   assign wdata    = stage.item.write_data;
   assign is_read  = stage.valid && (stage.item.req_type == REQ_READ);
   assign is_write = stage.valid && (stage.item.req_type == REQ_WRITE);
   assign is_raise = stage.valid && (stage.item.req_type == REQ_RAISE);
   assign q_valid  = qsel_ff < QUEUE_COUNT_WORD;
   assign qidx     = qsel_ff[QIDX_W-1:0];
   // selectors above 1 alias word 1
   assign drv_idx  = (drv_feat_sel_ff != 32'd0);
   assign soft_clear = is_write && (ofs == OFS_STATUS) && (wdata == 32'd0);

   always_comb begin
      unique case (ofs)
         OFS_MAGIC:        read_raw = MAGIC_WORD;
         OFS_VERSION:      read_raw = VERSION_WORD;
         OFS_DEVICE_ID:    read_raw = DEVICE_ID_WORD;
         OFS_VENDOR:       read_raw = VENDOR_WORD;
         OFS_DEV_FEAT:     read_raw = {31'd0, (dev_feat_sel_ff[31:1] == 31'd0)};
         OFS_DEV_FEAT_SEL: read_raw = dev_feat_sel_ff;
         OFS_DRV_FEAT:     read_raw = drv_feat_word_ff[drv_idx];
         OFS_DRV_FEAT_SEL: read_raw = drv_feat_sel_ff;
         OFS_QUEUE_SEL:    read_raw = qsel_ff;
         OFS_QUEUE_MAX:    read_raw = q_valid ? QUEUE_MAX_WORD : 32'd0;
         OFS_QUEUE_SIZE:   read_raw = q_valid ? queue_size_ff[qidx] : 32'd0;
         OFS_QUEUE_READY:  read_raw = q_valid ? queue_ready_ff[qidx] : 32'd0;
         OFS_INT_STATUS:   read_raw = {31'd0, irq_ff};
         OFS_STATUS:       read_raw = status_ff;
         OFS_COLS:         read_raw = CONSOLE_COLS;
         OFS_ROWS:         read_raw = CONSOLE_ROWS;
         default:          read_raw = 32'd0;
      endcase
   end

   always_comb begin
      read_data_in = 32'd0;
      if (is_read) begin
         case (stage.item.access_len)
            4'd1:    read_data_in = {24'd0, read_raw[7:0]};
            4'd2:    read_data_in = {16'd0, read_raw[15:0]};
            default: read_data_in = read_raw;
         endcase
      end
   end

   always_comb begin
      irq_in = irq_ff;
      if (is_raise) begin
         irq_in = 1'b1;
      end else if (is_write && (ofs == OFS_INT_ACK) && wdata[0]) begin
         irq_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || soft_clear) begin
         dev_feat_sel_ff <= 32'd0;
         drv_feat_sel_ff <= 32'd0;
         drv_feat_word_ff[0] <= 32'd0;
         drv_feat_word_ff[1] <= 32'd0;
         qsel_ff <= 32'd0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            queue_size_ff[i]  <= QUEUE_MAX_WORD;
            queue_ready_ff[i] <= 32'd0;
            desc_addr_ff[i]   <= 64'd0;
            driver_addr_ff[i] <= 64'd0;
            device_addr_ff[i] <= 64'd0;
         end
         status_ff <= 32'd0;
         irq_ff    <= 1'b0;
      end else begin
         irq_ff <= irq_in;
         if (is_write) begin
            unique case (ofs)
               OFS_DEV_FEAT_SEL: dev_feat_sel_ff <= wdata;
               OFS_DRV_FEAT:     drv_feat_word_ff[drv_idx] <= wdata;
               OFS_DRV_FEAT_SEL: drv_feat_sel_ff <= wdata;
               OFS_QUEUE_SEL:    qsel_ff <= wdata;
               OFS_QUEUE_SIZE:   if (q_valid) queue_size_ff[qidx] <= wdata;
               OFS_QUEUE_READY:  if (q_valid) queue_ready_ff[qidx] <= wdata;
               OFS_DESC_LO:      if (q_valid) desc_addr_ff[qidx][31:0] <= wdata;
               OFS_DESC_HI:      if (q_valid) desc_addr_ff[qidx][63:32] <= wdata;
               OFS_DRIVER_LO:    if (q_valid) driver_addr_ff[qidx][31:0] <= wdata;
               OFS_DRIVER_HI:    if (q_valid) driver_addr_ff[qidx][63:32] <= wdata;
               OFS_DEVICE_LO:    if (q_valid) device_addr_ff[qidx][31:0] <= wdata;
               OFS_DEVICE_HI:    if (q_valid) device_addr_ff[qidx][63:32] <= wdata;
               OFS_STATUS:       status_ff <= wdata;
               default:          ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_valid_ff <= 1'b0;
      end else begin
         done_valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
   end

   assign done.valid     = done_valid_ff;
   assign done.read_data = read_data_ff;

   assign view.sel_desc_addr   = q_valid ? desc_addr_ff[qidx]   : 64'd0;
   assign view.sel_driver_addr = q_valid ? driver_addr_ff[qidx] : 64'd0;
   assign view.sel_device_addr = q_valid ? device_addr_ff[qidx] : 64'd0;
   assign view.device_status   = status_ff;
   assign view.irq_pending     = irq_ff;

endmodule

[hw/rtl/vmcr_rsp_stage.sv]
// ----------------------------------------------------------------------------
// vmcr_rsp_stage
// Result register: joins read data with the state left by the transaction.
// ----------------------------------------------------------------------------
module vmcr_rsp_stage
   import vmcr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  done_stage_type done,
   input  state_view_type view,
   output logic           strobe,
   output rsp_item_type   item
);

   logic         strobe_ff;
   rsp_item_type item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= done.valid;
      end
   end

   // state view already holds the update of this transaction
   always_ff @(posedge clock) begin
      if (done.valid) begin
         item_ff.read_data       <= done.read_data;
         item_ff.sel_desc_addr   <= view.sel_desc_addr;
         item_ff.sel_driver_addr <= view.sel_driver_addr;
         item_ff.sel_device_addr <= view.sel_device_addr;
         item_ff.device_status   <= view.device_status;
         item_ff.irq_pending     <= view.irq_pending;
      end
   end

   assign strobe = strobe_ff;
   assign item   = item_ff;

endmodule

[hw/rtl/virtio_mmio_console_regs.sv]
// ----------------------------------------------------------------------------
// virtio_mmio_console_regs
// Virtio-MMIO version 2 register file of a console device.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------
//  request   | start / busy          | req_item  (req_item_type)
//  result    | rsp_strobe            | rsp_item  (rsp_item_type)
//
// One transaction per cycle; each result passes the input register, the
// register file and the result register before it is on the ports, one
// result per request, in order. The register update happens in the
// decode stage, so each access sees the one before it.
// Reset is synchronous; busy is high only while reset is asserted.
// The receiver cannot stall: a result is valid for the one cycle of rsp_strobe.
// ----------------------------------------------------------------------------
module virtio_mmio_console_regs
   import vmcr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   req_stage_type  req_stage;
   done_stage_type done_stage;
   state_view_type state_view;
   logic           accept;

   assign busy   = reset;
   assign accept = start && !busy;

   vmcr_req_stage u_req_stage (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .item  (req_item),
      .stage (req_stage)
   );

   vmcr_regfile u_regfile (
      .clock(clock),
      .reset(reset),
      .stage(req_stage),
      .done (done_stage),
      .view (state_view)
   );

   vmcr_rsp_stage u_rsp_stage (
      .clock (clock),
      .reset (reset),
      .done  (done_stage),
      .view  (state_view),
      .strobe(rsp_strobe),
      .item  (rsp_item)
   );

endmodule

[test/vmcr_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vmcr_check
// Watches the request and result channels of the console register block,
// keeps its own copy of the register state, and compares every result
// against the value predicted from the requests taken so far.
// ----------------------------------------------------------------------------
module vmcr_check
   import vmcr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_item_type req_item,
   input  logic         rsp_strobe,
   input  rsp_item_type rsp_item,
   output int           fail_count,
   output int           pending_count
);

   logic [31:0] dev_feat_sel;
   logic [31:0] drv_feat_sel;
   logic [31:0] drv_feat_word [2];
   logic [31:0] qsel;
   logic [31:0] q_size [NUM_QUEUES];
   logic [31:0] q_ready [NUM_QUEUES];
   logic [63:0] q_desc [NUM_QUEUES];
   logic [63:0] q_driver [NUM_QUEUES];
   logic [63:0] q_device [NUM_QUEUES];
   logic [31:0] status_reg;
   logic [31:0] irq_reg;

   rsp_item_type expected_rsps [$];
   int fails = 0;
   int waiting = 0;

   assign fail_count = fails;
   assign pending_count = waiting;

   task automatic clear_regs();
      dev_feat_sel = '0;
      drv_feat_sel = '0;
      drv_feat_word[0] = '0;
      drv_feat_word[1] = '0;
      qsel = '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         q_size[i] = QUEUE_MAX_WORD;
         q_ready[i] = '0;
         q_desc[i] = '0;
         q_driver[i] = '0;
         q_device[i] = '0;
      end
      status_reg = '0;
      irq_reg = '0;
   endtask

   function automatic logic queue_ok();
      return qsel < 32'(NUM_QUEUES);
   endfunction

   // selectors above 1 fold onto the upper driver feature word
   function automatic int drv_word_idx();
      return (drv_feat_sel < 32'd2) ? int'(drv_feat_sel[0]) : 1;
   endfunction

   function automatic logic [31:0] read_value(logic [11:0] ofs, logic [3:0] len);
      logic [31:0] v;
      logic        qv;
      int          qi;
      qv = queue_ok();
      qi = qv ? int'(qsel) : 0;
      case (ofs)
         OFS_MAGIC:        v = MAGIC_WORD;
         OFS_VERSION:      v = VERSION_WORD;
         OFS_DEVICE_ID:    v = DEVICE_ID_WORD;
         OFS_VENDOR:       v = VENDOR_WORD;
         OFS_DEV_FEAT:     v = (dev_feat_sel <= 32'd1) ? 32'd1 : 32'd0;
         OFS_DEV_FEAT_SEL: v = dev_feat_sel;
         OFS_DRV_FEAT:     v = drv_feat_word[drv_word_idx()];
         OFS_DRV_FEAT_SEL: v = drv_feat_sel;
         OFS_QUEUE_SEL:    v = qsel;
         OFS_QUEUE_MAX:    v = qv ? QUEUE_MAX_WORD : '0;
         OFS_QUEUE_SIZE:   v = qv ? q_size[qi] : '0;
         OFS_QUEUE_READY:  v = qv ? q_ready[qi] : '0;
         OFS_INT_STATUS:   v = irq_reg;
         OFS_STATUS:       v = status_reg;
         OFS_COLS:         v = CONSOLE_COLS;
         OFS_ROWS:         v = CONSOLE_ROWS;
         default:          v = '0;
      endcase
      if (len == 4'd1) return v & 32'h0000_00ff;
      if (len == 4'd2) return v & 32'h0000_ffff;
      return v;
   endfunction

   task automatic write_reg(logic [11:0] ofs, logic [31:0] data);
      logic qv;
      int   qi;
      qv = queue_ok();
      qi = qv ? int'(qsel) : 0;
      case (ofs)
         OFS_DEV_FEAT_SEL: dev_feat_sel = data;
         OFS_DRV_FEAT:     drv_feat_word[drv_word_idx()] = data;
         OFS_DRV_FEAT_SEL: drv_feat_sel = data;
         OFS_QUEUE_SEL:    qsel = data;
         OFS_QUEUE_SIZE:   if (qv) q_size[qi] = data;
         OFS_QUEUE_READY:  if (qv) q_ready[qi] = data;
         OFS_DESC_LO:      if (qv) q_desc[qi][31:0] = data;
         OFS_DESC_HI:      if (qv) q_desc[qi][63:32] = data;
         OFS_DRIVER_LO:    if (qv) q_driver[qi][31:0] = data;
         OFS_DRIVER_HI:    if (qv) q_driver[qi][63:32] = data;
         OFS_DEVICE_LO:    if (qv) q_device[qi][31:0] = data;
         OFS_DEVICE_HI:    if (qv) q_device[qi][63:32] = data;
         OFS_INT_ACK:      irq_reg = irq_reg & ~data;
         OFS_STATUS: begin
            if (data == '0) clear_regs();
            else status_reg = data;
         end
         default: ;
      endcase
   endtask

   // advance the register state by one transaction and form its result
   task automatic apply_access(input req_item_type it, output rsp_item_type res);
      res = '0;
      case (it.req_type)
         REQ_READ:  res.read_data = read_value(it.offset, it.access_len);
         REQ_WRITE: write_reg(it.offset, it.write_data);
         REQ_RAISE: irq_reg = irq_reg | 32'd1;
         default: ;
      endcase
      if (queue_ok()) begin
         res.sel_desc_addr = q_desc[int'(qsel)];
         res.sel_driver_addr = q_driver[int'(qsel)];
         res.sel_device_addr = q_device[int'(qsel)];
      end
      res.device_status = status_reg;
      res.irq_pending = irq_reg[0];
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         fails++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         clear_regs();
         expected_rsps.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (expected_rsps.size() == 0) begin
               fails++;
               $display("%0t: unexpected result: expected none, actual %h", $time, rsp_item);
            end else begin
               want = expected_rsps.pop_front();
               check_field("read_data", 64'(want.read_data), 64'(rsp_item.read_data));
               check_field("sel_desc_addr", want.sel_desc_addr, rsp_item.sel_desc_addr);
               check_field("sel_driver_addr", want.sel_driver_addr,
                           rsp_item.sel_driver_addr);
               check_field("sel_device_addr", want.sel_device_addr,
                           rsp_item.sel_device_addr);
               check_field("device_status", 64'(want.device_status),
                           64'(rsp_item.device_status));
               check_field("irq_pending", 64'(want.irq_pending),
                           64'(rsp_item.irq_pending));
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            apply_access(req_item, want);
            expected_rsps.push_back(want);
         end
      end
      waiting = expected_rsps.size();
   end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives register reads, writes, interrupt raises and undefined requests
// into the console register block: a directed pass over the register map
// and its corner cases, then random accesses with random gaps. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
   import vmcr_pkg::*;

   localparam logic [1:0]  REQ_UNDEFINED = 2'd3;
   localparam logic [11:0] OFS_CONFIG_GEN = 12'h0fc;
   localparam logic [11:0] OFS_TOP = 12'hfff;
   localparam int RANDOM_ITEMS = 1150;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 12;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   logic         rsp_strobe;
   req_item_type req_item = '0;
   rsp_item_type rsp_item;
   int           fail_count;
   int           pending_count;
   int           cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   virtio_mmio_console_regs uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   vmcr_check chk (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // present one transaction and hold it until the block takes it
   task automatic send_item(req_item_type it);
      @(negedge clock);
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic send(logic [1:0] kind, logic [11:0] ofs, logic [3:0] len,
                       logic [31:0] data);
      req_item_type it;
      it.req_type = kind;
      it.offset = ofs;
      it.access_len = len;
      it.write_data = data;
      send_item(it);
   endtask

   // drop start and put junk on the payload while idle
   task automatic idle_cycles(int n);
      logic [63:0] noise;
      repeat (n) begin
         @(negedge clock);
         noise = {$urandom(), $urandom()};
         start <= 1'b0;
         req_item <= noise[$bits(req_item_type)-1:0];
      end
   endtask

   task automatic drain_results();
      idle_cycles(1);
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [11:0] pick_offset();
      case ($urandom_range(0, 23))
         0:  return OFS_MAGIC;
         1:  return OFS_VERSION;
         2:  return OFS_DEVICE_ID;
         3:  return OFS_VENDOR;
         4:  return OFS_DEV_FEAT;
         5:  return OFS_DEV_FEAT_SEL;
         6:  return OFS_DRV_FEAT;
         7:  return OFS_DRV_FEAT_SEL;
         8:  return OFS_QUEUE_SEL;
         9:  return OFS_QUEUE_MAX;
         10: return OFS_QUEUE_SIZE;
         11: return OFS_QUEUE_READY;
         12: return OFS_INT_STATUS;
         13: return OFS_INT_ACK;
         14: return OFS_STATUS;
         15: return OFS_DESC_LO;
         16: return OFS_DESC_HI;
         17: return OFS_DRIVER_LO;
         18: return OFS_DRIVER_HI;
         19: return OFS_DEVICE_LO;
         20: return OFS_DEVICE_HI;
         21: return OFS_COLS;
         22: return OFS_ROWS;
         default: return OFS_CONFIG_GEN;
      endcase
   endfunction

   // keep selectors mostly in range so per-queue state gets exercised
   function automatic logic [31:0] pick_data(logic [11:0] ofs);
      int r;
      r = $urandom_range(0, 99);
      case (ofs)
         OFS_QUEUE_SEL: begin
            if (r < 75) return $urandom_range(0, NUM_QUEUES - 1);
            if (r < 90) return 32'(NUM_QUEUES);
            return $urandom();
         end
         OFS_DEV_FEAT_SEL, OFS_DRV_FEAT_SEL: begin
            if (r < 80) return $urandom_range(0, 2);
            return $urandom();
         end
         OFS_STATUS: begin
            if (r < 10) return '0;
            if (r < 55) return $urandom_range(1, 15);
            return $urandom();
         end
         OFS_INT_ACK: begin
            if (r < 40) return 32'd1;
            return $urandom();
         end
         default: begin
            if (r < 10) return '0;
            if (r < 20) return '1;
            return $urandom();
         end
      endcase
   endfunction

   function automatic req_item_type random_access();
      req_item_type it;
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) it.req_type = REQ_READ;
      else if (r < 85) it.req_type = REQ_WRITE;
      else if (r < 95) it.req_type = REQ_RAISE;
      else it.req_type = REQ_UNDEFINED;
      it.offset = ($urandom_range(0, 99) < 85) ? pick_offset() : 12'($urandom());
      case ($urandom_range(0, 9))
         0, 1:    it.access_len = 4'd1;
         2, 3:    it.access_len = 4'd2;
         4, 5:    it.access_len = 4'd4;
         default: it.access_len = 4'($urandom_range(0, 15));
      endcase
      it.write_data = pick_data(it.offset);
      return it;
   endfunction

   initial begin : stimulus
      bit no_gaps;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity words and read masking
      send(REQ_READ, OFS_MAGIC, 4'd4, '0);
      send(REQ_READ, OFS_VENDOR, 4'd1, '1);
      send(REQ_READ, OFS_VENDOR, 4'd2, '0);
      send(REQ_READ, OFS_VERSION, 4'd8, '0);
      send(REQ_READ, OFS_DEVICE_ID, 4'd0, '0);
      send(REQ_READ, OFS_COLS, 4'd2, '0);
      send(REQ_READ, OFS_ROWS, 4'd15, '0);
      // feature selectors, including driver selector above 1
      send(REQ_WRITE, OFS_DEV_FEAT_SEL, 4'd4, 32'd5);
      send(REQ_READ, OFS_DEV_FEAT, 4'd4, '0);
      send(REQ_WRITE, OFS_DRV_FEAT_SEL, 4'd4, 32'hffff_ffff);
      send(REQ_WRITE, OFS_DRV_FEAT, 4'd4, 32'hffff_ffff);
      send(REQ_READ, OFS_DRV_FEAT, 4'd4, '0);
      // queue 1 addresses, then an out-of-range selector
      send(REQ_WRITE, OFS_QUEUE_SEL, 4'd4, 32'(NUM_QUEUES - 1));
      send(REQ_WRITE, OFS_DESC_HI, 4'd4, 32'hffff_ffff);
      send(REQ_WRITE, OFS_DRIVER_LO, 4'd4, 32'h1234_5678);
      send(REQ_WRITE, OFS_DEVICE_HI, 4'd4, 32'h8000_0001);
      send(REQ_WRITE, OFS_QUEUE_SIZE, 4'd4, 32'hffff_ffff);
      send(REQ_WRITE, OFS_QUEUE_SEL, 4'd4, 32'hffff_ffff);
      send(REQ_READ, OFS_QUEUE_MAX, 4'd4, '0);
      send(REQ_WRITE, OFS_QUEUE_READY, 4'd4, 32'd1);
      // interrupt raise and acknowledge, undefined request, unmapped accesses
      send(REQ_RAISE, OFS_TOP, 4'd4, '1);
      send(REQ_UNDEFINED, OFS_STATUS, 4'd4, '0);
      send(REQ_WRITE, OFS_INT_ACK, 4'd4, 32'd1);
      send(REQ_WRITE, OFS_MAGIC, 4'd4, 32'hffff_ffff);
      send(REQ_READ, OFS_TOP, 4'd4, '0);
      // status write of zero resets everything
      send(REQ_WRITE, OFS_STATUS, 4'd4, '0);
      drain_results();

      no_gaps = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if (i == RANDOM_ITEMS / 2) drain_results();
         send_item(random_access());
         if (!no_gaps) idle_cycles(gap_len());
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/vmcr_pkg.sv
hw/rtl/vmcr_req_stage.sv
hw/rtl/vmcr_regfile.sv
hw/rtl/vmcr_rsp_stage.sv
hw/rtl/virtio_mmio_console_regs.sv
test/vmcr_check.sv
test/tb.sv
